// ----- rtl/core/fir_highpass_23tap_defines.svh -----
// ----------------------------------------------------------------------------
// fir_highpass_23tap_defines.svh
// Assertion macros shared by the checkers of the high-pass FIR block.
// ----------------------------------------------------------------------------
`ifndef FIR_HIGHPASS_23TAP_DEFINES_SVH
`define FIR_HIGHPASS_23TAP_DEFINES_SVH

// Next-cycle implication, switched off while reset is asserted.
`define FHP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Checks what the synchronous reset leaves behind in the next cycle.
`define FHP_ASSERT_AFTER_RESET(label, clk, rst_n, cons) \
  label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("post-reset check failed");

`endif

// ----- rtl/core/fhp_pkg.sv -----
// ----------------------------------------------------------------------------
// fhp_pkg
// Types, constants and the coefficient table of the high-pass FIR block.
// ----------------------------------------------------------------------------
package fhp_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int TAPS_DEF       = 23;
  localparam int COEF_FRAC_DEF  = 15;
  localparam int COEF_COUNT     = 23;
  localparam int COEF_CENTER    = 11;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       restart;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       fresh;
  } out_item_t;

  typedef struct packed {
    logic clear;  // zero the accumulator and drop any pending product
    logic load;   // mark the product of the current operands for accumulation
  } mac_ctrl_t;

  // Published coefficients in units of 1e-4, first half up to the center tap.
  function automatic int coef_e4(input int idx);
    int v;
    case (idx)
      0:       v = 59;
      1:       v = 768;
      2:       v = 62;
      3:       v = 33;
      4:       v = -113;
      5:       v = -303;
      6:       v = -528;
      7:       v = -763;
      8:       v = -983;
      9:       v = -1163;
      10:      v = -1281;
      11:      v = 8678;
      default: v = 0;
    endcase
    return v;
  endfunction

  // Fixed-point coefficient for one tap, rounded half away from zero.
  // Evaluated only at elaboration.
  function automatic int coef_q(input int idx, input int frac);
    int c;
    int mag;
    int q;
    int half_idx;
    if (idx >= COEF_COUNT) begin
      return 0;
    end
    half_idx = (idx > COEF_CENTER) ? (COEF_COUNT - 1 - idx) : idx;
    c   = coef_e4(half_idx);
    mag = (c < 0) ? -c : c;
    q   = (mag * (1 << frac) + 5000) / 10000;
    return (c < 0) ? -q : q;
  endfunction

endpackage

// ----- rtl/core/fir_highpass_23tap.sv -----
// A filtered item passes through the MAC pass, the drain state and the output state;
// the shared multiplier steps through one tap per cycle, and no new item is taken
// until its result is registered. A priming item gives its held result in the next
// cycle and the block is ready again at once unless that result is stalled.
// Synchronous active-low reset clears the sequencer and output valid, zeroes the
// held output and reloads the priming count with TAPS.
// ----------------------------------------------------------------------------
// fir_highpass_23tap
// Symmetric high-pass FIR on signed 16-bit audio, one MAC shared by all taps.
// ----------------------------------------------------------------------------
module fir_highpass_23tap #(
  parameter int TAPS           = fhp_pkg::TAPS_DEF,
  parameter int COEF_FRAC_BITS = fhp_pkg::COEF_FRAC_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  fhp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output fhp_pkg::out_item_t out_data
);
  import fhp_pkg::*;

  localparam int CW  = COEF_FRAC_BITS + 1;
  localparam int TW  = $clog2(TAPS);
  localparam int PCW = $clog2(TAPS + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MAC   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  logic [1:0]                 state_r, state_nxt;
  logic [TW-1:0]              tap_r, tap_nxt;
  logic [PCW-1:0]             prime_r, prime_nxt;
  logic [PCW-1:0]             prime_eff;
  logic signed [SAMPLE_W-1:0] held_r, held_nxt;
  logic                       out_valid_r, out_valid_nxt;
  out_item_t                  out_data_r, out_data_nxt;
  logic signed [SAMPLE_W-1:0] line_r [TAPS];
  logic signed [CW-1:0]       coef_w [TAPS];
  logic signed [SAMPLE_W-1:0] mac_result;
  mac_ctrl_t                  mac_ctrl;
  logic                       in_fire;
  logic                       priming;

  for (genvar g = 0; g < TAPS; g++) begin : g_coef
    assign coef_w[g] = CW'(coef_q(g, COEF_FRAC_BITS));
  end

  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign in_fire   = in_valid && !in_stall;
  assign prime_eff = in_data.restart ? PCW'(TAPS) : prime_r;
  assign priming   = (prime_eff != '0);

  assign mac_ctrl.clear = in_fire && !priming;
  assign mac_ctrl.load  = (state_r == ST_MAC);

  always_comb begin
    state_nxt     = state_r;
    tap_nxt       = tap_r;
    prime_nxt     = prime_r;
    held_nxt      = held_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (priming) begin
            prime_nxt     = prime_eff - PCW'(1);
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{filtered: held_r, fresh: 1'b0};
          end else begin
            state_nxt = ST_MAC;
            tap_nxt   = '0;
          end
        end
      end
      ST_MAC: begin
        if (tap_r == TW'(TAPS - 1)) begin
          state_nxt = ST_DRAIN;
          tap_nxt   = '0;
        end else begin
          tap_nxt = tap_r + TW'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // The output register is empty here: the item was only taken once
        // the previous result had left.
        held_nxt      = mac_result;
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{filtered: mac_result, fresh: 1'b1};
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tap_r       <= '0;
      prime_r     <= PCW'(TAPS);
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tap_r       <= tap_nxt;
      prime_r     <= prime_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // The delay line shifts in a new sample on transfer. During the MAC pass
  // it rotates once, so tap k sits at the head in step k and the line is
  // back in order when the pass ends.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      line_r[0] <= in_data.sample;
      for (int i = 1; i < TAPS; i++) begin
        line_r[i] <= line_r[i-1];
      end
    end else if (state_r == ST_MAC) begin
      for (int i = 0; i < TAPS - 1; i++) begin
        line_r[i] <= line_r[i+1];
      end
      line_r[TAPS-1] <= line_r[0];
    end
  end

  fhp_mac #(
    .TAPS           (TAPS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (mac_ctrl),
    .sample_i (line_r[0]),
    .coef_i   (coef_w[tap_r]),
    .result   (mac_result)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/core/fhp_mac.sv -----
// ----------------------------------------------------------------------------
// fhp_mac
// Shared multiply-accumulate unit with toward-zero scaling and saturation.
// ----------------------------------------------------------------------------
module fhp_mac #(
  parameter int TAPS           = fhp_pkg::TAPS_DEF,
  parameter int COEF_FRAC_BITS = fhp_pkg::COEF_FRAC_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  fhp_pkg::mac_ctrl_t                    ctrl,
  input  logic signed [fhp_pkg::SAMPLE_W-1:0]   sample_i,
  input  logic signed [COEF_FRAC_BITS:0]        coef_i,
  output logic signed [fhp_pkg::SAMPLE_W-1:0]   result
);
  import fhp_pkg::*;

  localparam int CW = COEF_FRAC_BITS + 1;
  localparam int PW = SAMPLE_W + CW;
  localparam int AW = PW + $clog2(TAPS);

  localparam logic signed [AW-1:0] BIAS = (AW'(1) << COEF_FRAC_BITS) - AW'(1);
  localparam logic signed [AW-1:0] MAXV = AW'(32767);
  localparam logic signed [AW-1:0] MINV = AW'(-32768);

  logic signed [PW-1:0] prod_r;
  logic                 prod_vld_r;
  logic signed [AW-1:0] acc_r;
  logic signed [AW-1:0] acc_nxt;
  logic signed [AW-1:0] biased;
  logic signed [AW-1:0] quo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= ctrl.load & ~ctrl.clear;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= sample_i * coef_i;
    if (ctrl.clear) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc_nxt = acc_r + AW'(prod_r);

  // Adding the bias before the arithmetic shift makes negative sums truncate
  // toward zero instead of toward minus infinity.
  assign biased = acc_r[AW-1] ? (acc_r + BIAS) : acc_r;
  assign quo    = biased >>> COEF_FRAC_BITS;

  always_comb begin
    if (quo > MAXV) begin
      result = 16'sh7fff;
    end else if (quo < MINV) begin
      result = -16'sh8000;
    end else begin
      result = $signed(quo[SAMPLE_W-1:0]);
    end
  end

endmodule

// ----- rtl/core/fhp_checker.sv -----
// ----------------------------------------------------------------------------
// fhp_checker
// Port-level checks of the high-pass FIR block, bound to its top level.
// ----------------------------------------------------------------------------
`include "fir_highpass_23tap_defines.svh"

module fhp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input fhp_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input fhp_pkg::out_item_t out_data
);
  import fhp_pkg::*;

  // A stalled result stays offered and unchanged.
  `FHP_ASSERT_NEXT(a_out_valid_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `FHP_ASSERT_NEXT(a_out_data_hold, clk, rst_n, out_valid && out_stall, $stable(out_data))

  // A restart transfer always primes, so its result is the held value, not fresh.
  `FHP_ASSERT_NEXT(a_restart_holds, clk, rst_n, in_valid && !in_stall && in_data.restart, out_valid && !out_data.fresh)

  // Reset leaves no result pending.
  `FHP_ASSERT_AFTER_RESET(a_reset_empty, clk, rst_n, !out_valid)

endmodule

bind fir_highpass_23tap fhp_checker u_fhp_checker (.*);

// ----- verif/fir_highpass_23tap_checker.sv -----
// ----------------------------------------------------------------------------
// fir_highpass_23tap_checker
// Watches both channels of the high-pass FIR block. It keeps its own copy of
// the delay line, priming count and held output, predicts one result per input
// transfer and compares every output transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module fir_highpass_23tap_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  fhp_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  fhp_pkg::out_item_t out_data,
  output int                 mismatches,
  output int                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAPS = fhp_pkg::TAPS_DEF;
  localparam int FRAC = fhp_pkg::COEF_FRAC_DEF;

  logic signed [15:0]  line [TAPS];
  int                  prime_left;
  logic signed [15:0]  held_out;
  fhp_pkg::out_item_t  predicted_q [$];

  // Q15 weight of one tap; the table is symmetric about the center tap.
  function automatic longint tap_weight(input int idx);
    int     m;
    int     e4;
    longint mag;
    m = (idx > 11) ? 22 - idx : idx;
    case (m)
      0:       e4 = 59;
      1:       e4 = 768;
      2:       e4 = 62;
      3:       e4 = 33;
      4:       e4 = -113;
      5:       e4 = -303;
      6:       e4 = -528;
      7:       e4 = -763;
      8:       e4 = -983;
      9:       e4 = -1163;
      10:      e4 = -1281;
      11:      e4 = 8678;
      default: e4 = 0;
    endcase
    if (idx >= 23) begin
      e4 = 0;
    end
    mag = (e4 < 0) ? -e4 : e4;
    mag = (mag * (longint'(1) << FRAC) + 5000) / 10000;
    return (e4 < 0) ? -mag : mag;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic filter_step(input fhp_pkg::in_item_t it);
    longint             acc;
    longint             y;
    fhp_pkg::out_item_t res;
    acc = 0;
    if (it.restart) begin
      prime_left = TAPS;
    end
    for (int i = TAPS - 1; i > 0; i--) begin
      line[i] = line[i-1];
    end
    line[0] = it.sample;
    if (prime_left > 0) begin
      prime_left--;
      res.filtered = held_out;
      res.fresh    = 1'b0;
    end else begin
      for (int i = 0; i < TAPS; i++) begin
        acc += longint'(line[i]) * tap_weight(i);
      end
      // Signed division truncates toward zero, as the block does.
      y = acc / (longint'(1) << FRAC);
      if (y > 32767) begin
        y = 32767;
      end else if (y < -32768) begin
        y = -32768;
      end
      held_out     = y[15:0];
      res.filtered = held_out;
      res.fresh    = 1'b1;
    end
    predicted_q.push_back(res);
  endtask

  always @(posedge clk) begin
    fhp_pkg::out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < TAPS; i++) begin
        line[i] = '0;
      end
      prime_left = TAPS;
      held_out   = '0;
      mismatches = 0;
      predicted_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_q.size() == 0) begin
          report_mismatch($sformatf("output transfer with nothing predicted (filtered %0d)",
                                    out_data.filtered));
        end else begin
          want = predicted_q.pop_front();
          if (out_data.filtered !== want.filtered) begin
            report_mismatch($sformatf("filtered got %0d, expected %0d",
                                      out_data.filtered, want.filtered));
          end
          if (out_data.fresh !== want.fresh) begin
            report_mismatch($sformatf("fresh got %b, expected %b",
                                      out_data.fresh, want.fresh));
          end
        end
      end
      if (in_valid && !in_stall) begin
        filter_step(in_data);
      end
    end
    outstanding = predicted_q.size();
  end

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Drives the high-pass FIR with directed saturation and restart items, then
// random sequences of full-range noise, small signals, DC, full-scale tones,
// saturating patterns and restarts, with bursty input and a varying output stall.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAPS        = fhp_pkg::TAPS_DEF;
  localparam int ITEM_TARGET = 1750;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  fhp_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  fhp_pkg::out_item_t out_data;
  int                 mismatches;
  int                 outstanding;

  int burst_left = 0;
  int sent = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  fir_highpass_23tap uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  fir_highpass_23tap_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Output stall runs in modes of random length: none, light, heavy, long runs.
  int stall_mode = 0;
  int mode_left  = 0;
  int run_left   = 0;
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(20, 300);
    end else begin
      mode_left--;
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 2) == 0);
        2: out_stall <= ($urandom_range(0, 4) != 0);
        default: begin
          if (run_left == 0) begin
            run_left = $urandom_range(1, 40);
            out_stall <= ~out_stall;
          end else begin
            run_left--;
          end
        end
      endcase
    end
  end

  // Sign of a tap weight: taps 0-3, the center and their mirrors are positive.
  function automatic bit tap_positive(input int idx);
    int m;
    m = (idx > 11) ? 22 - idx : idx;
    return (m <= 3) || (m == 11);
  endfunction

  // One input transfer; a new burst starts after a random gap.
  task automatic send(input int s, input bit rs);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 60) : $urandom_range(0, 4);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid        = 1'b1;
    in_data.sample  = s[15:0];
    in_data.restart = rs;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // Line set to the tap signs or their opposites, driving the sum to either rail.
  task automatic send_rail(input bit pos);
    int v;
    for (int k = 0; k < TAPS; k++) begin
      v = (tap_positive(TAPS - 1 - k) == pos) ? 32767 : -32768;
      send(v, 1'b0);
    end
  endtask

  initial begin
    int kind;
    int len;
    int v;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Directed: priming from reset, positive saturation, then a restart.
    send(16'sh5a5a, 1'b0);
    send_rail(1'b1);
    send(-32768, 1'b1);

    while (sent < ITEM_TARGET) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2: begin
          len = $urandom_range(10, 60);
          repeat (len) send($urandom_range(0, 65535) - 32768, $urandom_range(0, 79) == 0);
        end
        3: begin
          len = $urandom_range(10, 40);
          repeat (len) send($urandom_range(0, 64) - 32, $urandom_range(0, 79) == 0);
        end
        4, 5: begin
          send_rail($urandom_range(0, 1));
          repeat ($urandom_range(0, 3)) send($urandom_range(0, 65535) - 32768, 1'b0);
        end
        6: begin
          v   = $urandom_range(0, 65535) - 32768;
          len = $urandom_range(20, 40);
          repeat (len) send(v, 1'b0);
        end
        7: begin
          len = $urandom_range(20, 40);
          for (int k = 0; k < len; k++) begin
            send(k[0] ? -32768 : 32767, 1'b0);
          end
        end
        8: begin
          // Restart followed by a partial or full refill of the line.
          send($urandom_range(0, 65535) - 32768, 1'b1);
          len = $urandom_range(1, 30);
          repeat (len) send($urandom_range(0, 65535) - 32768, $urandom_range(0, 15) == 0);
        end
        default: begin
          len = $urandom_range(5, 30);
          repeat (len) send($urandom_range(0, 1) ? $urandom_range(32700, 32767)
                                                 : -$urandom_range(32700, 32768), 1'b0);
        end
      endcase
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (TAPS + 20) @(negedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
